/* rtl/multi_reader_event_fifo_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the multi-reader event FIFO
// Clocked, reset-gated property shorthands used by the top level.
// ----------------------------------------------------------------------------
`ifndef MULTI_READER_EVENT_FIFO_MACROS_SVH
`define MULTI_READER_EVENT_FIFO_MACROS_SVH

// ante true at an edge requires cons true at the same edge
`define MREF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cond must never hold
`define MREF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

/* rtl/mref_pkg.sv */
// ----------------------------------------------------------------------------
// mref_pkg
// Sizes, command and result types shared by the event FIFO modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mref_pkg;

  localparam int NUM_QUEUES  = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 32;

  // fixed field widths on the ports
  localparam int ACT_W  = 3;
  localparam int QID_W  = 3;
  localparam int EVT_W  = 32;
  localparam int STAT_W = 2;
  localparam int FILL_W = 5;

  localparam int SLOT_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int DEPTH_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int ENTRY_W = TIME_BITS + 1;

  // request codes on the action field
  localparam logic [ACT_W-1:0] ACT_BCAST  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_OPEN   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLOSE  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_FLUSH  = 3'd5;

  // classified command kinds
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_BCAST  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_OPEN   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLOSE  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_BAD    = 3'd6;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOQ    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOSLOT = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              in_range;
    logic [QID_W-1:0]  qid;
    logic [SLOT_W-1:0] slot;
    logic [EVT_W-1:0]  evt_time;
    logic              falling;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [QID_W-1:0]  result_queue;
    logic [EVT_W-1:0]  read_time;
    logic              read_falling;
    logic [FILL_W-1:0] fill_level;
  } res_t;

endpackage

`default_nettype wire

/* rtl/multi_reader_event_fifo.sv */
// ----------------------------------------------------------------------------
// multi_reader_event_fifo
// Set of reader queues of timestamped sensor edge events with drop-oldest.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream (action in s_tuser), one result leaves on
// the m_ stream for every request (status in m_tuser).
// A request passes a two-entry command queue, then the executor handles it.
// A read waits in an extra state for the registered entry store read port;
// broadcast walks all NUM_QUEUES slots, and open walks the slots up to the
// first free one, both one slot per cycle.
// The executor handles one request at a time.
// The front keeps taking up to two items while a result waits on m_tready.
// Back pressure on m_ holds the result register and stops the executor;
// once the command queue is full, s_tready drops.
// Reset (rst, synchronous) closes all queues and empties both streams.
// Entry store contents are not cleared; only live entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_reader_event_fifo_macros.svh"

module multi_reader_event_fifo (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // queue_id[2:0], event_time[34:3],
                                      // edge_falling[35], zero pad[39:36]
  input  wire logic [2:0]  s_tuser,   // action[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // result_queue[2:0], read_time[34:3],
                                      // read_falling[35], fill_level[40:36],
                                      // zero pad[47:41]
  output logic [1:0]       m_tuser    // status[1:0]
);
  import mref_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  res_t res;

  // classify and queue incoming items
  mref_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_action  (s_tuser),
    .in_qid     (s_tdata[2:0]),
    .in_time    (s_tdata[34:3]),
    .in_falling (s_tdata[35]),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  // execute against queue table and entry store, hold result until taken
  mref_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_in    (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res)
  );

  // pack the result item
  assign m_tuser = res.status;
  assign m_tdata = {7'd0, res.fill_level, res.read_falling, res.read_time,
                    res.result_queue};

  `MREF_ASSERT_IMPLIES(a_pop_needs_cmd, cmd_pop, cmd_valid, "command popped from empty queue")
  `MREF_ASSERT_IMPLIES(a_err_no_fill, m_tvalid && (m_tuser != STAT_OK), m_tdata[40:36] == 5'd0, "error result with nonzero fill")
  `MREF_ASSERT_IMPLIES(a_err_no_data, m_tvalid && (m_tuser != STAT_OK), m_tdata[35:3] == 33'd0, "error result with read data")
  `MREF_ASSERT_NEVER(a_out_after_reset, $past(rst) && m_tvalid, "result valid right after reset")

endmodule

`default_nettype wire

/* rtl/mref_ram.sv */
// ----------------------------------------------------------------------------
// mref_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module mref_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/mref_front.sv */
// ----------------------------------------------------------------------------
// mref_front
// Classify incoming requests and hold them in a two-entry command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mref_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [mref_pkg::ACT_W-1:0] in_action,
  input  wire logic [mref_pkg::QID_W-1:0] in_qid,
  input  wire logic [mref_pkg::EVT_W-1:0] in_time,
  input  wire logic                       in_falling,
  output logic                            cmd_valid,
  output mref_pkg::cmd_t                  cmd,
  input  wire logic                       cmd_pop
);
  import mref_pkg::*;

  cmd_t       fq [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       cls;
  logic       push;

  // map the action code onto a command kind; codes past flush are invalid
  always_comb begin
    cls.qid      = in_qid;
    cls.slot     = SLOT_W'(in_qid);
    cls.in_range = (32'(in_qid) < NUM_QUEUES);
    cls.evt_time = in_time;
    cls.falling  = in_falling;
    case (in_action)
      ACT_BCAST:  cls.kind = KIND_BCAST;
      ACT_INSERT: cls.kind = KIND_INSERT;
      ACT_READ:   cls.kind = KIND_READ;
      ACT_OPEN:   cls.kind = KIND_OPEN;
      ACT_CLOSE:  cls.kind = KIND_CLOSE;
      ACT_FLUSH:  cls.kind = KIND_FLUSH;
      default:    cls.kind = KIND_BAD;
    endcase
  end

  assign in_ready  = (fill != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = fq[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fq[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, cmd_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/mref_back.sv */
// ----------------------------------------------------------------------------
// mref_back
// Execute commands on the queue table and entry store, one slot per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mref_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  input  wire mref_pkg::cmd_t cmd_in,
  output logic                cmd_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output mref_pkg::res_t      res
);
  import mref_pkg::*;

  localparam int SUM_W = COUNT_W + 1;
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_RDWAIT = 2'd2;

  logic [1:0]            state, state_next;
  cmd_t                  cmd, cmd_next;
  logic [SLOT_W-1:0]     idx, idx_next;
  logic [NUM_QUEUES-1:0] slot_open, slot_open_next;
  logic [DEPTH_W-1:0]    head [NUM_QUEUES];
  logic [DEPTH_W-1:0]    head_next [NUM_QUEUES];
  logic [COUNT_W-1:0]    count [NUM_QUEUES];
  logic [COUNT_W-1:0]    count_next [NUM_QUEUES];
  logic [COUNT_W-1:0]    rd_fill, rd_fill_next;
  logic                  out_valid_next;
  res_t                  res_next;

  logic                  cur_open, exists, full, last;
  logic [DEPTH_W-1:0]    cur_head, app_pos, inc_head;
  logic [COUNT_W-1:0]    cur_count;
  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;

  function automatic logic [DEPTH_W-1:0] wrap(input logic [SUM_W-1:0] s);
    if (32'(s) >= QUEUE_DEPTH) begin
      return DEPTH_W'(32'(s) - QUEUE_DEPTH);
    end
    return DEPTH_W'(s);
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] q,
                                                   input logic [DEPTH_W-1:0] p);
    return ADDR_W'(32'(q) * QUEUE_DEPTH + 32'(p));
  endfunction

  assign cur_open  = slot_open[idx];
  assign cur_head  = head[idx];
  assign cur_count = count[idx];
  assign exists    = cmd.in_range && cur_open;
  assign full      = (32'(cur_count) == QUEUE_DEPTH);
  assign last      = (32'(idx) == NUM_QUEUES - 1);
  assign inc_head  = wrap(SUM_W'(cur_head) + SUM_W'(1));
  // a full ring overwrites its oldest entry and moves the head past it
  assign app_pos   = full ? cur_head : wrap(SUM_W'(cur_head) + SUM_W'(cur_count));

  assign ram_waddr = store_addr(idx, app_pos);
  assign ram_raddr = store_addr(idx, cur_head);
  assign ram_wdata = {cmd.falling, TIME_BITS'(cmd.evt_time)};

  mref_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next     = state;
    cmd_next       = cmd;
    idx_next       = idx;
    slot_open_next = slot_open;
    head_next      = head;
    count_next     = count;
    rd_fill_next   = rd_fill;
    out_valid_next = out_valid && !out_ready;
    res_next       = res;
    cmd_pop        = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    case (state)
      S_IDLE: begin
        if (cmd_valid && !out_valid) begin
          cmd_pop    = 1'b1;
          cmd_next   = cmd_in;
          state_next = S_EXEC;
          if (cmd_in.kind == KIND_BCAST || cmd_in.kind == KIND_OPEN) begin
            idx_next = '0;
          end else begin
            idx_next = cmd_in.slot;
          end
        end
      end

      S_EXEC: begin
        res_next.status       = STAT_OK;
        res_next.result_queue = cmd.qid;
        res_next.read_time    = '0;
        res_next.read_falling = 1'b0;
        res_next.fill_level   = '0;
        case (cmd.kind)
          KIND_BCAST: begin
            if (cur_open) begin
              ram_we = 1'b1;
              if (full) begin
                head_next[idx] = inc_head;
              end else begin
                count_next[idx] = cur_count + COUNT_W'(1);
              end
            end
            if (last) begin
              out_valid_next = 1'b1;
              state_next     = S_IDLE;
            end else begin
              idx_next = idx + SLOT_W'(1);
            end
          end
          KIND_INSERT: begin
            out_valid_next = 1'b1;
            state_next     = S_IDLE;
            if (!exists) begin
              res_next.status = STAT_NOQ;
            end else begin
              ram_we = 1'b1;
              if (full) begin
                head_next[idx]      = inc_head;
                res_next.fill_level = FILL_W'(cur_count);
              end else begin
                count_next[idx]     = cur_count + COUNT_W'(1);
                res_next.fill_level = FILL_W'(cur_count + COUNT_W'(1));
              end
            end
          end
          KIND_READ: begin
            if (!exists) begin
              res_next.status = STAT_NOQ;
              out_valid_next  = 1'b1;
              state_next      = S_IDLE;
            end else if (cur_count == '0) begin
              res_next.status = STAT_EMPTY;
              out_valid_next  = 1'b1;
              state_next      = S_IDLE;
            end else begin
              ram_re          = 1'b1;
              head_next[idx]  = inc_head;
              count_next[idx] = cur_count - COUNT_W'(1);
              rd_fill_next    = cur_count - COUNT_W'(1);
              state_next      = S_RDWAIT;
            end
          end
          KIND_OPEN: begin
            if (!cur_open) begin
              slot_open_next[idx]   = 1'b1;
              head_next[idx]        = '0;
              count_next[idx]       = '0;
              res_next.result_queue = QID_W'(idx);
              out_valid_next        = 1'b1;
              state_next            = S_IDLE;
            end else if (last) begin
              res_next.status = STAT_NOSLOT;
              out_valid_next  = 1'b1;
              state_next      = S_IDLE;
            end else begin
              idx_next = idx + SLOT_W'(1);
            end
          end
          KIND_CLOSE: begin
            out_valid_next = 1'b1;
            state_next     = S_IDLE;
            if (!exists) begin
              res_next.status = STAT_NOQ;
            end else begin
              slot_open_next[idx] = 1'b0;
              head_next[idx]      = '0;
              count_next[idx]     = '0;
            end
          end
          KIND_FLUSH: begin
            out_valid_next = 1'b1;
            state_next     = S_IDLE;
            if (!exists) begin
              res_next.status = STAT_NOQ;
            end else if (cur_count == '0) begin
              res_next.status = STAT_EMPTY;
            end else begin
              head_next[idx]  = '0;
              count_next[idx] = '0;
            end
          end
          default: begin
            res_next.status = STAT_NOQ;
            out_valid_next  = 1'b1;
            state_next      = S_IDLE;
          end
        endcase
      end

      S_RDWAIT: begin
        res_next.status       = STAT_OK;
        res_next.result_queue = cmd.qid;
        res_next.read_time    = EVT_W'(ram_rdata[TIME_BITS-1:0]);
        res_next.read_falling = ram_rdata[TIME_BITS];
        res_next.fill_level   = FILL_W'(rd_fill);
        out_valid_next        = 1'b1;
        state_next            = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd     <= cmd_next;
    idx     <= idx_next;
    rd_fill <= rd_fill_next;
    res     <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      slot_open <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      slot_open <= slot_open_next;
      head      <= head_next;
      count     <= count_next;
    end
  end

endmodule

`default_nettype wire

/* dv/mref_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mref_checker
// Watches both streams of the event FIFO, predicts each result and compares.
// ----------------------------------------------------------------------------
module mref_checker
  import mref_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // queue_id[2:0], event_time[34:3], edge_falling[35]
  input  logic [2:0]  s_tuser,   // action[2:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // result_queue[2:0], read_time[34:3],
                                 // read_falling[35], fill_level[40:36]
  input  logic [1:0]  m_tuser,   // status[1:0]
  output int          mismatch_count,
  output int          pending_count
);

  typedef struct packed {
    logic [TIME_BITS-1:0] stamp;
    logic                 falling;
  } edge_rec_t;

  // shadow of the queue slots
  logic               queue_live [NUM_QUEUES];
  logic [DEPTH_W-1:0] ring_head  [NUM_QUEUES];
  logic [COUNT_W-1:0] ring_fill  [NUM_QUEUES];
  edge_rec_t          ring_mem   [STORE_DEPTH];

  res_t expected_results [$];

  task automatic pop_oldest(input int q);
    ring_head[q] = DEPTH_W'((int'(ring_head[q]) + 1) % QUEUE_DEPTH);
    ring_fill[q] = ring_fill[q] - COUNT_W'(1);
  endtask

  task automatic push_edge(input int q, input logic [EVT_W-1:0] t, input logic f);
    int pos;
    if (int'(ring_fill[q]) >= QUEUE_DEPTH) pop_oldest(q);
    pos = q * QUEUE_DEPTH + (int'(ring_head[q]) + int'(ring_fill[q])) % QUEUE_DEPTH;
    ring_mem[pos].stamp   = t[TIME_BITS-1:0];
    ring_mem[pos].falling = f;
    ring_fill[q] = ring_fill[q] + COUNT_W'(1);
  endtask

  task automatic predict_event_result(input logic [ACT_W-1:0] act, input logic [QID_W-1:0] qid,
                                      input logic [EVT_W-1:0] t, input logic f,
                                      output res_t r);
    bit present;
    bit found;
    int q;
    int pos;
    q = int'(qid);
    present = 1'b0;
    if (q < NUM_QUEUES) present = queue_live[q];
    r = '0;
    r.status       = STAT_OK;
    r.result_queue = qid;
    case (act)
      ACT_BCAST: begin
        for (int i = 0; i < NUM_QUEUES; i++)
          if (queue_live[i]) push_edge(i, t, f);
      end
      ACT_INSERT: begin
        if (!present) r.status = STAT_NOQ;
        else begin
          push_edge(q, t, f);
          r.fill_level = FILL_W'(ring_fill[q]);
        end
      end
      ACT_READ: begin
        if (!present) r.status = STAT_NOQ;
        else if (ring_fill[q] == 0) r.status = STAT_EMPTY;
        else begin
          pos = q * QUEUE_DEPTH + int'(ring_head[q]);
          r.read_time    = EVT_W'(ring_mem[pos].stamp);
          r.read_falling = ring_mem[pos].falling;
          pop_oldest(q);
          r.fill_level = FILL_W'(ring_fill[q]);
        end
      end
      ACT_OPEN: begin
        found = 1'b0;
        r.status = STAT_NOSLOT;
        for (int i = 0; i < NUM_QUEUES; i++) begin
          if (!found && !queue_live[i]) begin
            found         = 1'b1;
            queue_live[i] = 1'b1;
            ring_head[i]  = '0;
            ring_fill[i]  = '0;
            r.status       = STAT_OK;
            r.result_queue = QID_W'(i);
          end
        end
      end
      ACT_CLOSE: begin
        if (!present) r.status = STAT_NOQ;
        else begin
          queue_live[q] = 1'b0;
          ring_head[q]  = '0;
          ring_fill[q]  = '0;
        end
      end
      ACT_FLUSH: begin
        if (!present) r.status = STAT_NOQ;
        else if (ring_fill[q] == 0) r.status = STAT_EMPTY;
        else begin
          ring_head[q] = '0;
          ring_fill[q] = '0;
        end
      end
      default: r.status = STAT_NOQ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    res_t got;
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        queue_live[i] = 1'b0;
        ring_head[i]  = '0;
        ring_fill[i]  = '0;
      end
      expected_results.delete();
    end else begin
      // compare first: a result never belongs to an item accepted at the same edge
      if (m_tvalid && m_tready) begin
        got.status       = m_tuser;
        got.result_queue = m_tdata[2:0];
        got.read_time    = m_tdata[34:3];
        got.read_falling = m_tdata[35];
        got.fill_level   = m_tdata[40:36];
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with no request pending: st=%0d q=%0d t=%h f=%0d fill=%0d",
                     $realtime, got.status, got.result_queue, got.read_time,
                     got.read_falling, got.fill_level);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.result_queue !== want.result_queue ||
              got.read_time !== want.read_time || got.read_falling !== want.read_falling ||
              got.fill_level !== want.fill_level) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"%0t: mismatch exp st=%0d q=%0d t=%h f=%0d fill=%0d,",
                        " got st=%0d q=%0d t=%h f=%0d fill=%0d"},
                       $realtime, want.status, want.result_queue, want.read_time,
                       want.read_falling, want.fill_level, got.status, got.result_queue,
                       got.read_time, got.read_falling, got.fill_level);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        predict_event_result(s_tuser, s_tdata[2:0], s_tdata[34:3], s_tdata[35], want);
        expected_results.push_back(want);
      end
    end
    pending_count = expected_results.size();
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives open, close, flush, insert, broadcast and read requests into the
// event FIFO with random gaps on both streams; the checker predicts results.
// ----------------------------------------------------------------------------
module tb;
  import mref_pkg::*;

  localparam int DIRECTED_ITEMS = 27;
  localparam int RANDOM_ITEMS   = 750;
  localparam int DRAIN_AT       = 400;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int TAIL_CYCLES    = 40;

  // action codes the block does not define
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // queue_id[2:0], event_time[34:3], edge_falling[35], zero pad[39:36]
  logic [2:0]  s_tuser;   // action[2:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // result_queue[2:0], read_time[34:3], read_falling[35],
                          // fill_level[40:36], zero pad[47:41]
  logic [1:0]  m_tuser;   // status[1:0]

  int mismatch_count;
  int pending_count;
  int cycle_count;
  int items_sent;

  // calm flags switch off idling on one side for a stretch
  bit calm_tx;
  bit calm_rx;

  // which slots stimulus believes are open, used only to aim requests
  bit slot_taken [NUM_QUEUES];

  multi_reader_event_fifo i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  mref_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run; the bound is many times the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Favor the timestamp extremes once in a while.
  function automatic logic [EVT_W-1:0] pick_stamp();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return EVT_W'($urandom);
  endfunction

  // Aim at an open slot most of the time, at any slot otherwise.
  function automatic logic [QID_W-1:0] pick_live_qid();
    int live [$];
    for (int i = 0; i < NUM_QUEUES; i++)
      if (slot_taken[i]) live.push_back(i);
    if (live.size() == 0 || $urandom_range(0, 19) == 0) return QID_W'($urandom_range(0, 7));
    return QID_W'(live[$urandom_range(0, live.size() - 1)]);
  endfunction

  // Present one item after a random gap and hold it until accepted.
  task automatic send_request(input logic [ACT_W-1:0] act, input logic [QID_W-1:0] qid,
                              input logic [EVT_W-1:0] stamp, input logic falling);
    int gap;
    bit placed;
    gap = calm_tx ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {4'b0, falling, stamp, qid};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    // track slot allocation: open takes the lowest free slot
    if (act == ACT_OPEN) begin
      placed = 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        if (!placed && !slot_taken[i]) begin
          slot_taken[i] = 1'b1;
          placed = 1'b1;
        end
      end
    end else if (act == ACT_CLOSE && int'(qid) < NUM_QUEUES) begin
      slot_taken[qid] = 1'b0;
    end
  endtask

  // Drop valid and hold the sender until every issued item has produced its result.
  task automatic wait_for_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // Result side: random stalls on m_tready.
  initial begin : sink
    int hold;
    int run;
    m_tready = 1'b0;
    forever begin
      if (calm_rx) begin
        hold = 0;
        run  = 1;
      end else begin
        hold = pick_gap();
        run  = $urandom_range(1, 6);
      end
      @(negedge clk);
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      m_tready <= 1'b1;
      repeat (run - 1) @(negedge clk);
    end
  end

  initial begin : stimulus
    int roll;
    int len;
    bit drained;
    logic [QID_W-1:0] q;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    drained  = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed: requests on closed slots, spare actions, empty broadcast.
    send_request(ACT_READ,   3'd0, '0, 1'b0);
    send_request(ACT_BCAST,  3'd7, 32'h1234_5678, 1'b1);
    send_request(ACT_FLUSH,  3'd0, '0, 1'b0);
    send_request(ACT_CLOSE,  3'd7, '0, 1'b0);
    send_request(ACT_INSERT, 3'd3, '1, 1'b1);
    send_request(ACT_SPARE_LO, 3'd2, '1, 1'b1);
    send_request(ACT_SPARE_HI, 3'd5, '0, 1'b0);
    // fill every slot, then one open too many
    repeat (NUM_QUEUES) send_request(ACT_OPEN, 3'd0, '0, 1'b0);
    send_request(ACT_OPEN,   3'd5, '1, 1'b1);
    // read and flush of an empty queue
    send_request(ACT_READ,   3'd1, '0, 1'b0);
    send_request(ACT_FLUSH,  3'd1, '0, 1'b0);
    // timestamp extremes, then a broadcast behind them
    send_request(ACT_INSERT, 3'd0, '0, 1'b0);
    send_request(ACT_INSERT, 3'd0, '1, 1'b1);
    send_request(ACT_BCAST,  3'd4, 32'hA5A5_5A5A, 1'b1);
    send_request(ACT_READ,   3'd0, '0, 1'b0);
    send_request(ACT_FLUSH,  3'd1, '0, 1'b0);
    // close a queue that still holds an entry, reopen it
    send_request(ACT_CLOSE,  3'd3, '0, 1'b0);
    send_request(ACT_OPEN,   3'd6, '0, 1'b0);
    send_request(ACT_READ,   3'd0, '0, 1'b0);
    send_request(ACT_READ,   3'd3, '0, 1'b0);

    // Random: mostly well-formed runs on open queues, some noise.
    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      calm_tx = ($urandom_range(0, 99) < 15);
      calm_rx = ($urandom_range(0, 99) < 15);
      if (!drained && items_sent >= DRAIN_AT) begin
        wait_for_results();
        drained = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 38) begin
        // insert runs long enough to wrap and drop the oldest
        q   = pick_live_qid();
        len = $urandom_range(1, 20);
        repeat (len) send_request(ACT_INSERT, q, pick_stamp(), 1'($urandom_range(0, 1)));
      end else if (roll < 55) begin
        q   = pick_live_qid();
        len = $urandom_range(1, 18);
        repeat (len) send_request(ACT_READ, q, pick_stamp(), 1'($urandom_range(0, 1)));
      end else if (roll < 65) begin
        len = $urandom_range(1, 4);
        repeat (len)
          send_request(ACT_BCAST, QID_W'($urandom_range(0, 7)), pick_stamp(),
                       1'($urandom_range(0, 1)));
      end else if (roll < 73) begin
        send_request(ACT_OPEN, QID_W'($urandom_range(0, 7)), pick_stamp(),
                     1'($urandom_range(0, 1)));
      end else if (roll < 80) begin
        send_request(ACT_CLOSE, pick_live_qid(), pick_stamp(), 1'($urandom_range(0, 1)));
      end else if (roll < 86) begin
        send_request(ACT_FLUSH, pick_live_qid(), pick_stamp(), 1'($urandom_range(0, 1)));
      end else begin
        // noise: any action code on any slot
        send_request(ACT_W'($urandom_range(0, 7)), QID_W'($urandom_range(0, 7)),
                     pick_stamp(), 1'($urandom_range(0, 1)));
      end
    end

    // Drop valid, let all results drain, then watch for strays.
    calm_rx = 1'b0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
